// ===== src/wsfr_pkg.sv =====
// Package with the shared types and constants of the WebSocket frame receiver.
`default_nettype none
package wsfr_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] MASK_BIT      = 8'h80;
  localparam logic [6:0] LEN_DIRECT_MAX = 7'd125;
  localparam logic [6:0] LEN_EXT16      = 7'd126;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DONE    = 3'd5,
    PH_REFUSED = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_MASKED     = 3'd2,
    ST_LARGE      = 3'd3,
    ST_INCOMPLETE = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic [2:0] status_code;
  } out_item_t;

  typedef struct packed {
    logic       has_payload;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic       has_status;
    status_t    status_code;
  } cmd_t;

endpackage
`default_nettype wire

// ===== src/wsfr_front.sv =====
// Header parser that classifies each input byte and issues result commands.
`default_nettype none
module wsfr_front (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wsfr_pkg::in_item_t in_data,
  output logic               push,
  output wsfr_pkg::cmd_t     push_cmd,
  input  wire                queue_full
);
  import wsfr_pkg::*;

  phase_t      phase, phase_next, phase_adv;
  logic [15:0] frame_length, frame_length_next, length_adv;
  status_t     error_latched, error_latched_next, error_adv;
  logic        accept;
  logic [15:0] length_dec;
  logic [15:0] length_lo;
  logic [6:0]  len_field;

  assign in_stall   = queue_full;
  assign accept     = in_valid && !queue_full;
  assign len_field  = in_data.data_byte[6:0];
  assign length_dec = frame_length - 16'd1;
  assign length_lo  = {frame_length[15:8], in_data.data_byte};

  always_comb begin
    phase_adv  = phase;
    length_adv = frame_length;
    error_adv  = error_latched;
    case (phase)
      PH_FIRST: begin
        phase_adv = PH_SECOND;
      end
      PH_SECOND: begin
        if ((in_data.data_byte & MASK_BIT) != 8'h00) begin
          error_adv = ST_MASKED;
          phase_adv = PH_REFUSED;
        end else if (len_field <= LEN_DIRECT_MAX) begin
          length_adv = {9'd0, len_field};
          phase_adv  = (len_field == 7'd0) ? PH_DONE : PH_PAYLOAD;
        end else if (len_field == LEN_EXT16) begin
          phase_adv = PH_LEN_HI;
        end else begin
          error_adv = ST_LARGE;
          phase_adv = PH_REFUSED;
        end
      end
      PH_LEN_HI: begin
        length_adv = {in_data.data_byte, 8'h00};
        phase_adv  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_adv = length_lo;
        phase_adv  = (length_lo == 16'd0) ? PH_DONE : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        length_adv = length_dec;
        if (length_dec == 16'd0) begin
          phase_adv = PH_DONE;
        end
      end
      default: begin
        phase_adv = phase;
      end
    endcase
  end

  always_comb begin
    phase_next         = phase;
    frame_length_next  = frame_length;
    error_latched_next = error_latched;
    if (accept) begin
      if (in_data.buffer_end) begin
        phase_next         = PH_FIRST;
        frame_length_next  = 16'd0;
        error_latched_next = ST_OK;
      end else begin
        phase_next         = phase_adv;
        frame_length_next  = length_adv;
        error_latched_next = error_adv;
      end
    end
  end

  always_comb begin
    push_cmd.has_payload  = (phase == PH_PAYLOAD);
    push_cmd.payload_byte = in_data.data_byte;
    push_cmd.frame_end    = (length_dec == 16'd0);
    push_cmd.has_status   = in_data.buffer_end;
    if (error_adv != ST_OK) begin
      push_cmd.status_code = error_adv;
    end else if (phase_adv == PH_SECOND) begin
      push_cmd.status_code = ST_SHORT;
    end else if (phase_adv == PH_DONE) begin
      push_cmd.status_code = ST_OK;
    end else begin
      push_cmd.status_code = ST_INCOMPLETE;
    end
    push = accept && (push_cmd.has_payload || push_cmd.has_status);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FIRST;
      frame_length  <= 16'd0;
      error_latched <= ST_OK;
    end else begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      error_latched <= error_latched_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/wsfr_queue.sv =====
// Short command queue between the header parser and the result emitter.
`default_nettype none
module wsfr_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  wsfr_pkg::cmd_t  push_cmd,
  output logic            full,
  input  wire             pop,
  output logic            not_empty,
  output wsfr_pkg::cmd_t  head_cmd
);
  import wsfr_pkg::*;

  cmd_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_W-1:0] count, count_next;
  logic                   do_push, do_pop;

  assign full      = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== src/wsfr_back.sv =====
// Result emitter that turns queued commands into payload and status transfers.
`default_nettype none
module wsfr_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 not_empty,
  input  wsfr_pkg::cmd_t      head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output wsfr_pkg::out_item_t out_data
);
  import wsfr_pkg::*;

  logic      payload_sent, payload_sent_next;
  logic      out_valid_next;
  out_item_t result;
  logic      load;
  logic      send_payload;

  assign load         = not_empty && (!out_valid || !out_stall);
  assign send_payload = head_cmd.has_payload && !payload_sent;

  always_comb begin
    result            = '0;
    pop               = 1'b0;
    payload_sent_next = payload_sent;
    if (send_payload) begin
      result.payload_byte = head_cmd.payload_byte;
      result.frame_end    = head_cmd.frame_end;
    end else begin
      result.is_status   = 1'b1;
      result.status_code = head_cmd.status_code;
    end
    if (load) begin
      if (send_payload && head_cmd.has_status) begin
        payload_sent_next = 1'b1;
      end else begin
        pop               = 1'b1;
        payload_sent_next = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      payload_sent <= 1'b0;
    end else begin
      out_valid    <= out_valid_next;
      payload_sent <= payload_sent_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

// ===== src/websocket_frame_receiver_core.sv =====
// Top level of the WebSocket frame receiver.
// The input channel takes one byte of a received buffer per transfer, with
// buffer_end set on the buffer's last byte. The block parses a server frame
// header (mask bit must be clear, 7-bit or 16-bit length) and passes on the
// payload bytes of the frame, frame_end set on the last one. On the buffer's
// last byte a status transfer (is_status set) follows any payload transfer.
// Input bytes are taken at one per cycle while the command queue has room.
// After its byte is accepted, a result passes through the command queue and
// the output register, one result per cycle while out_stall is low, so a byte
// that makes both a payload and a status result gives two output transfers.
// Reset clears the parser to expect the first header byte of a new buffer
// and empties the queue and the output register.
// When the receiver stalls, the output register holds its result, the
// four-entry queue fills, and then in_stall rises until room frees up.
`default_nettype none
module websocket_frame_receiver_core (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wsfr_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output wsfr_pkg::out_item_t  out_data
);
  import wsfr_pkg::*;

  logic push, pop, full, not_empty;
  cmd_t push_cmd, head_cmd;

  wsfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (full)
  );

  wsfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_cmd  (head_cmd)
  );

  wsfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== tb/websocket_frame_receiver_core_test.sv =====
// Self-checking testbench for the WebSocket frame receiver core.
`default_nettype none
module websocket_frame_receiver_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wsfr_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_BYTES = 1600;

  class frame_scoreboard;
    phase_t phase;
    logic [15:0] remaining;
    status_t refusal;
    out_item_t awaited[$];
    int unsigned failures;

    function new();
      restart();
      failures = 0;
    endfunction

    function void restart();
      phase = PH_FIRST;
      remaining = '0;
      refusal = ST_OK;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_byte(in_item_t item);
      logic [6:0] len_code;
      status_t code;
      out_item_t res;
      len_code = item.data_byte[6:0];
      case (phase)
        PH_FIRST: phase = PH_SECOND;
        PH_SECOND: begin
          if ((item.data_byte & MASK_BIT) != '0) begin
            refusal = ST_MASKED;
            phase = PH_REFUSED;
          end else if (len_code <= LEN_DIRECT_MAX) begin
            remaining = {9'd0, len_code};
            phase = (len_code == '0) ? PH_DONE : PH_PAYLOAD;
          end else if (len_code == LEN_EXT16) begin
            phase = PH_LEN_HI;
          end else begin
            refusal = ST_LARGE;
            phase = PH_REFUSED;
          end
        end
        PH_LEN_HI: begin
          remaining = {item.data_byte, 8'h00};
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          remaining[7:0] = item.data_byte;
          phase = (remaining == '0) ? PH_DONE : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          remaining = remaining - 16'd1;
          res = '0;
          res.payload_byte = item.data_byte;
          res.frame_end = (remaining == '0);
          if (remaining == '0) begin
            phase = PH_DONE;
          end
          awaited.push_back(res);
        end
        default: ;
      endcase
      if (item.buffer_end) begin
        if (refusal != ST_OK) begin
          code = refusal;
        end else if (phase == PH_SECOND) begin
          code = ST_SHORT;
        end else if (phase == PH_DONE) begin
          code = ST_OK;
        end else begin
          code = ST_INCOMPLETE;
        end
        res = '0;
        res.is_status = 1'b1;
        res.status_code = code;
        awaited.push_back(res);
        restart();
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: %p", got);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (got.is_status !== want.is_status) begin
        $error("is_status: expected %0h, got %0h", want.is_status, got.is_status);
        failures++;
      end
      if (got.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
        failures++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0h, got %0h", want.frame_end, got.frame_end);
        failures++;
      end
      if (got.status_code !== want.status_code) begin
        $error("status_code: expected %0h, got %0h", want.status_code, got.status_code);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  frame_scoreboard frames;
  int unsigned sent_count = 0;
  int unsigned burst_left = 8;
  int unsigned idle_cycles = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_count = 40;

  websocket_frame_receiver_core i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_count <= $urandom_range(20, 120);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_count[2];
    endcase
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      frames.note_byte(in_data);
    end
    if (!rst && out_valid && !out_stall) begin
      frames.check_result(out_data);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** websocket_frame_receiver_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input in_item_t item);
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_buffer(input byte_q_t bytes);
    in_item_t item;
    foreach (bytes[i]) begin
      item.data_byte = bytes[i];
      item.buffer_end = (i == bytes.size() - 1);
      send_byte(item);
    end
  endtask

  initial begin
    byte_q_t frame_bytes;
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    logic [15:0] ext_len;
    frames = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    frame_bytes = '{8'h81};
    send_buffer(frame_bytes);
    frame_bytes = '{8'h82, 8'h85, 8'h33};
    send_buffer(frame_bytes);
    frame_bytes = '{8'h00, 8'h7F, 8'hAA};
    send_buffer(frame_bytes);
    frame_bytes = '{8'h82, 8'h00};
    send_buffer(frame_bytes);
    frame_bytes = '{8'h81, 8'h02, 8'h00, 8'hFF, 8'h55};
    send_buffer(frame_bytes);
    frame_bytes = '{8'hFF, 8'h7D, 8'h11};
    send_buffer(frame_bytes);
    frame_bytes = '{8'h81, 8'h7E, 8'h00, 8'h00};
    send_buffer(frame_bytes);
    frame_bytes = '{8'h81, 8'h7E, 8'hFF};
    send_buffer(frame_bytes);
    frame_bytes = '{8'h81, 8'h7E, 8'h00, 8'h01, 8'hA5};
    send_buffer(frame_bytes);

    while (sent_count < RANDOM_BYTES) begin
      frame_bytes = {};
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
        frame_bytes.push_back(len[7:0]);
      end else if (kind < 80) begin
        ext_len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 20))
                                              : 16'($urandom_range(0, 65535));
        frame_bytes.push_back({1'b0, LEN_EXT16});
        frame_bytes.push_back(ext_len[15:8]);
        frame_bytes.push_back(ext_len[7:0]);
        len = (ext_len > 16'd40) ? 40 : int'(ext_len);
      end else if (kind < 92) begin
        if ($urandom_range(0, 1) == 0) begin
          frame_bytes.push_back(8'($urandom_range(128, 255)));
        end else begin
          frame_bytes.push_back(8'h7F);
        end
        len = $urandom_range(0, 5);
      end else begin
        len = $urandom_range(0, 3);
      end
      repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
      if (kind < 92 && $urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, frame_bytes.size() - 1);
        repeat (cut) void'(frame_bytes.pop_back());
      end else if (kind < 92 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_buffer(frame_bytes);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (frames.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frames.failures == 0 && frames.pending() == 0) begin
      $display("** websocket_frame_receiver_core: PASSED **");
    end else begin
      $display("** websocket_frame_receiver_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
